FILE: rtl/core/itmn_pkg.sv
// Package for the island tile mask and noise core.
// Holds the request and result types, the hash functions and the fixed-point constants.
// Depends on nothing; every module of the core imports it.
package itmn_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int SMP_BITS   = 20;
    localparam int SIZE_BITS  = 13;
    localparam int DIFF_BITS  = COORD_BITS + 3;
    localparam int DIST_BITS  = 2 * COORD_BITS + 3;
    localparam int M_BITS     = 2 * COORD_BITS + 2;
    localparam int Q_BITS     = 30;
    localparam int ROOT_BITS  = Q_BITS / 2;
    localparam int RES_BITS   = Q_BITS + 1;
    localparam int RAD_BITS   = 16;
    localparam int THR_BITS   = 30;
    localparam int LHS_BITS   = RAD_BITS + 30;
    localparam int GRID_BITS  = COORD_BITS - 1;
    localparam int SX_BITS    = COORD_BITS + FRAC_BITS - 2;
    localparam int BL_BITS    = SMP_BITS + FRAC_BITS + 2;

    localparam int NOISE_LAT  = 7;
    localparam int DIV_LAT    = Q_BITS;
    localparam int SQRT_LAT   = ROOT_BITS;
    localparam int LAST_STAGE = 4 + DIV_LAT + SQRT_LAT + 1;
    localparam int SIDE_DEPTH = 4 + DIV_LAT + SQRT_LAT - (1 + NOISE_LAT);
    localparam int SAT_DEPTH  = DIV_LAT + SQRT_LAT;

    localparam logic [SX_BITS-1:0] NOISE_STEP =
        SX_BITS'(((15 << FRAC_BITS) + 50) / 100);

    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
    localparam logic [31:0] VARIANT_SALT = 32'd9973;

    localparam logic [THR_BITS-1:0] THR_BASE  = THR_BITS'(445 * 1048575);
    localparam logic [THR_BITS-1:0] THR_SLOPE = THR_BITS'(350);
    localparam logic [LHS_BITS-1:0] LHS_SCALE = LHS_BITS'(1000 * 1048575);
    localparam logic [RAD_BITS-1:0] RADIUS_ONE = RAD_BITS'(32768);

    localparam logic [SIZE_BITS-1:0] WORLD_MAX   = SIZE_BITS'(4096);
    localparam logic [SIZE_BITS-1:0] WORLD_RESET = SIZE_BITS'(64);

    localparam logic [1:0] CFG_SEED   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [COORD_BITS-1:0] tile_x;
        logic [COORD_BITS-1:0] tile_y;
    } tile_t;

    typedef struct packed {
        logic                in_shape;
        logic [1:0]          variant;
        logic [RAD_BITS-1:0] radius;
    } result_t;

    typedef struct packed {
        logic [THR_BITS-1:0] thr;
        logic [1:0]          variant;
    } side_t;

    function automatic logic [31:0] hash_a(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] s);
        return x * HASH_MUL_X + y * HASH_MUL_Y + ((s << 31) - s);
    endfunction

    function automatic logic [31:0] hash_b(input logic [31:0] h);
        return (h ^ (h >> 13)) * HASH_MUL_MIX;
    endfunction

    function automatic logic [31:0] hash_fin(input logic [31:0] h);
        return h ^ (h >> 16);
    endfunction

endpackage

FILE: rtl/core/itmn_noise.sv
// Value noise pipeline: grid hashing, bilinear blend and land threshold, plus tile variant.
// Seven register stages under a shared advance enable.
// Depends on itmn_pkg.
module itmn_noise (
    input  logic                           clk,
    input  logic                           en,
    input  logic [31:0]                    seed,
    input  logic [itmn_pkg::COORD_BITS-1:0] x,
    input  logic [itmn_pkg::COORD_BITS-1:0] y,
    output itmn_pkg::side_t                side
);
    import itmn_pkg::*;

    logic [SX_BITS-1:0]   sx;
    logic [SX_BITS-1:0]   sy;
    logic [GRID_BITS-1:0] gx1_reg;
    logic [GRID_BITS-1:0] gy1_reg;
    logic [FRAC_BITS-1:0] fx_reg [1:4];
    logic [FRAC_BITS-1:0] fy_reg [1:5];
    logic [31:0]          va1_reg;
    logic [31:0]          vb2_reg;
    logic [1:0]           var_reg [3:6];
    logic [31:0]          ca2_reg [4];
    logic [31:0]          cb3_reg [4];
    logic [SMP_BITS-1:0]  smp4_reg [4];
    logic [SMP_BITS-1:0]  row5_reg [2];
    logic [SMP_BITS-1:0]  n6_reg;
    logic [31:0]          cx_next [4];
    logic [31:0]          cy_next [4];
    logic [31:0]          var_fin;
    logic [31:0]          cell_fin [4];
    logic [BL_BITS-1:0]   bl0;
    logic [BL_BITS-1:0]   bl1;
    logic [BL_BITS-1:0]   bl2;
    logic [BL_BITS-1:0]   one;
    side_t                side_reg;

    assign sx  = SX_BITS'(x) * NOISE_STEP;
    assign sy  = SX_BITS'(y) * NOISE_STEP;
    assign one = BL_BITS'(1) << FRAC_BITS;

    always_comb
    begin
        cx_next[0] = 32'(gx1_reg);
        cx_next[1] = 32'(gx1_reg) + 32'd1;
        cx_next[2] = 32'(gx1_reg);
        cx_next[3] = 32'(gx1_reg) + 32'd1;
        cy_next[0] = 32'(gy1_reg);
        cy_next[1] = 32'(gy1_reg);
        cy_next[2] = 32'(gy1_reg) + 32'd1;
        cy_next[3] = 32'(gy1_reg) + 32'd1;
        var_fin = hash_fin(vb2_reg);
        for (int c = 0; c < 4; c++)
        begin
            cell_fin[c] = hash_fin(cb3_reg[c]);
        end
        bl0 = BL_BITS'(smp4_reg[0]) * (one - BL_BITS'(fx_reg[4]))
            + BL_BITS'(smp4_reg[1]) * BL_BITS'(fx_reg[4]);
        bl1 = BL_BITS'(smp4_reg[2]) * (one - BL_BITS'(fx_reg[4]))
            + BL_BITS'(smp4_reg[3]) * BL_BITS'(fx_reg[4]);
        bl2 = BL_BITS'(row5_reg[0]) * (one - BL_BITS'(fy_reg[5]))
            + BL_BITS'(row5_reg[1]) * BL_BITS'(fy_reg[5]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gx1_reg   <= sx[FRAC_BITS +: GRID_BITS];
            gy1_reg   <= sy[FRAC_BITS +: GRID_BITS];
            fx_reg[1] <= sx[FRAC_BITS-1:0];
            fy_reg[1] <= sy[FRAC_BITS-1:0];
            va1_reg   <= hash_a(32'(x), 32'(y), seed + VARIANT_SALT);
            for (int i = 2; i <= 4; i++)
            begin
                fx_reg[i] <= fx_reg[i-1];
            end
            for (int i = 2; i <= 5; i++)
            begin
                fy_reg[i] <= fy_reg[i-1];
            end
            vb2_reg    <= hash_b(va1_reg);
            var_reg[3] <= var_fin[1:0];
            for (int i = 4; i <= 6; i++)
            begin
                var_reg[i] <= var_reg[i-1];
            end
            for (int c = 0; c < 4; c++)
            begin
                ca2_reg[c]  <= hash_a(cx_next[c], cy_next[c], seed);
                cb3_reg[c]  <= hash_b(ca2_reg[c]);
                smp4_reg[c] <= cell_fin[c][SMP_BITS-1:0];
            end
            row5_reg[0]      <= bl0[FRAC_BITS +: SMP_BITS];
            row5_reg[1]      <= bl1[FRAC_BITS +: SMP_BITS];
            n6_reg           <= bl2[FRAC_BITS +: SMP_BITS];
            side_reg.thr     <= THR_BASE + THR_BITS'(n6_reg) * THR_SLOPE;
            side_reg.variant <= var_reg[6];
        end
    end

    assign side = side_reg;

endmodule

FILE: rtl/core/itmn_div.sv
// Radix-2 restoring divider, one quotient bit per register stage.
// Gives floor(r0 * 2^Q_BITS / m) for r0 < m. The user must hold m steady while items
// are in flight; the block does not enforce it. Depends on itmn_pkg.
module itmn_div (
    input  logic                         clk,
    input  logic                         en,
    input  logic [itmn_pkg::M_BITS-1:0]  r0,
    input  logic [itmn_pkg::M_BITS-1:0]  m,
    output logic [itmn_pkg::Q_BITS-1:0]  q
);
    import itmn_pkg::*;

    logic [M_BITS-1:0] r_reg  [DIV_LAT];
    logic [Q_BITS-1:0] q_reg  [DIV_LAT];
    logic [M_BITS-1:0] r_next [DIV_LAT];
    logic [Q_BITS-1:0] q_next [DIV_LAT];
    logic [M_BITS:0]   t      [DIV_LAT];
    logic [Q_BITS-1:0] q_in   [DIV_LAT];

    always_comb
    begin
        for (int k = 0; k < DIV_LAT; k++)
        begin
            t[k]    = (k == 0) ? {r0, 1'b0} : {r_reg[(k == 0) ? 0 : k - 1], 1'b0};
            q_in[k] = (k == 0) ? '0 : q_reg[(k == 0) ? 0 : k - 1];
            if (t[k] >= {1'b0, m})
            begin
                r_next[k] = M_BITS'(t[k] - {1'b0, m});
                q_next[k] = {q_in[k][Q_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next[k] = t[k][M_BITS-1:0];
                q_next[k] = {q_in[k][Q_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_LAT; k++)
            begin
                r_reg[k] <= r_next[k];
                q_reg[k] <= q_next[k];
            end
        end
    end

    assign q = q_reg[DIV_LAT-1];

endmodule

FILE: rtl/core/itmn_sqrt.sv
// Digit-by-digit integer square root, one result bit per register stage.
// Gives floor(sqrt(v)) for a Q_BITS-wide operand.
// Depends on itmn_pkg.
module itmn_sqrt (
    input  logic                            clk,
    input  logic                            en,
    input  logic [itmn_pkg::Q_BITS-1:0]     v,
    output logic [itmn_pkg::ROOT_BITS-1:0]  root
);
    import itmn_pkg::*;

    logic [Q_BITS-1:0]   v_reg    [SQRT_LAT];
    logic [RES_BITS-1:0] res_reg  [SQRT_LAT];
    logic [Q_BITS-1:0]   v_next   [SQRT_LAT];
    logic [RES_BITS-1:0] res_next [SQRT_LAT];
    logic [Q_BITS-1:0]   v_in     [SQRT_LAT];
    logic [RES_BITS-1:0] res_in   [SQRT_LAT];
    logic [RES_BITS-1:0] bit_k    [SQRT_LAT];
    logic [RES_BITS-1:0] sum      [SQRT_LAT];

    always_comb
    begin
        for (int k = 0; k < SQRT_LAT; k++)
        begin
            v_in[k]   = (k == 0) ? v : v_reg[(k == 0) ? 0 : k - 1];
            res_in[k] = (k == 0) ? '0 : res_reg[(k == 0) ? 0 : k - 1];
            bit_k[k]  = RES_BITS'(1) << (2 * (SQRT_LAT - 1 - k));
            sum[k]    = res_in[k] + bit_k[k];
            if ({1'b0, v_in[k]} >= sum[k])
            begin
                v_next[k]   = v_in[k] - sum[k][Q_BITS-1:0];
                res_next[k] = (res_in[k] >> 1) + bit_k[k];
            end
            else
            begin
                v_next[k]   = v_in[k];
                res_next[k] = res_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_LAT; k++)
            begin
                v_reg[k]   <= v_next[k];
                res_reg[k] <= res_next[k];
            end
        end
    end

    assign root = res_reg[SQRT_LAT-1][ROOT_BITS-1:0];

endmodule

FILE: rtl/core/island_tile_mask_noise_core.sv
// Top level of the island tile mask and noise core.
// Instantiates itmn_noise, itmn_div and itmn_sqrt; depends on itmn_pkg.
//
// One tile request is taken per clock while tile_stall is low; each result passes through the
// 30-stage distance divider and the 15-stage square root that follows it. The whole
// pipeline advances together and halts only when a result is held at the output and another
// one is about to reach it. Configuration is written through cfg_* and is always ready.
module island_tile_mask_noise_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tile_valid,
    output logic              tile_stall,
    input  itmn_pkg::tile_t   tile,
    output logic              result_valid,
    input  logic              result_stall,
    output itmn_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import itmn_pkg::*;

    logic [31:0]            seed_reg;
    logic [SIZE_BITS-1:0]   width_reg;
    logic [SIZE_BITS-1:0]   height_reg;
    logic [SIZE_BITS-1:0]   wc_reg;
    logic [SIZE_BITS-1:0]   hc_reg;
    logic [SIZE_BITS-1:0]   wc_next;
    logic [SIZE_BITS-1:0]   hc_next;
    logic [M_BITS-1:0]      m_reg;
    logic                   en;
    logic                   out_en;
    logic                   vld_reg [1:LAST_STAGE];
    logic [COORD_BITS-1:0]  x1_reg;
    logic [COORD_BITS-1:0]  y1_reg;
    logic signed [DIFF_BITS-1:0] dx2_reg;
    logic signed [DIFF_BITS-1:0] dy2_reg;
    logic signed [2*DIFF_BITS-1:0] dxx;
    logic signed [2*DIFF_BITS-1:0] dyy;
    logic [DIST_BITS-1:0]   d3_reg;
    logic                   sat4_reg;
    logic [M_BITS-1:0]      r4_reg;
    logic                   sat_reg [SAT_DEPTH];
    side_t                  noise_side;
    side_t                  side_reg [SIDE_DEPTH];
    logic [Q_BITS-1:0]      q;
    logic [ROOT_BITS-1:0]   root;
    logic [RAD_BITS-1:0]    rad_next;
    logic [RAD_BITS-1:0]    rad_reg;
    logic [LHS_BITS-1:0]    lhs_reg;
    side_t                  side_last_reg;
    logic                   result_valid_reg;
    result_t                result_reg;

    always_comb
    begin
        if (width_reg == '0)
        begin
            wc_next = SIZE_BITS'(1);
        end
        else if (width_reg > WORLD_MAX)
        begin
            wc_next = WORLD_MAX;
        end
        else
        begin
            wc_next = width_reg;
        end
        if (height_reg == '0)
        begin
            hc_next = SIZE_BITS'(1);
        end
        else if (height_reg > WORLD_MAX)
        begin
            hc_next = WORLD_MAX;
        end
        else
        begin
            hc_next = height_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            width_reg  <= WORLD_RESET;
            height_reg <= WORLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SEED:   seed_reg   <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data[SIZE_BITS-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[SIZE_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        wc_reg <= wc_next;
        hc_reg <= hc_next;
        m_reg  <= M_BITS'(wc_reg) * M_BITS'(wc_reg) + M_BITS'(hc_reg) * M_BITS'(hc_reg);
    end

    assign cfg_ready  = 1'b1;
    assign out_en     = !(result_valid_reg && result_stall);
    assign en         = !(result_valid_reg && result_stall && vld_reg[LAST_STAGE]);
    assign tile_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= LAST_STAGE; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg[1] <= tile_valid;
                for (int i = 2; i <= LAST_STAGE; i++)
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
            if (out_en)
            begin
                result_valid_reg <= vld_reg[LAST_STAGE];
            end
        end
    end

    assign dxx = dx2_reg * dx2_reg;
    assign dyy = dy2_reg * dy2_reg;
    assign rad_next = sat_reg[SAT_DEPTH-1] ? RADIUS_ONE : RAD_BITS'(root);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= tile.tile_x;
            y1_reg   <= tile.tile_y;
            dx2_reg  <= signed'({2'b00, x1_reg, 1'b0}) - signed'({2'b00, wc_reg});
            dy2_reg  <= signed'({2'b00, y1_reg, 1'b0}) - signed'({2'b00, hc_reg});
            d3_reg   <= DIST_BITS'(unsigned'(dxx)) + DIST_BITS'(unsigned'(dyy));
            sat4_reg <= d3_reg >= DIST_BITS'(m_reg);
            r4_reg   <= (d3_reg >= DIST_BITS'(m_reg)) ? '0 : d3_reg[M_BITS-1:0];
            sat_reg[0] <= sat4_reg;
            for (int i = 1; i < SAT_DEPTH; i++)
            begin
                sat_reg[i] <= sat_reg[i-1];
            end
            side_reg[0] <= noise_side;
            for (int i = 1; i < SIDE_DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            rad_reg       <= rad_next;
            lhs_reg       <= LHS_BITS'(rad_next) * LHS_SCALE;
            side_last_reg <= side_reg[SIDE_DEPTH-1];
            if (out_en)
            begin
                result_reg.in_shape <= lhs_reg <= LHS_BITS'({side_last_reg.thr, 15'b0});
                result_reg.variant  <= side_last_reg.variant;
                result_reg.radius   <= rad_reg;
            end
        end
    end

    itmn_noise u_noise (
        .clk  (clk),
        .en   (en),
        .seed (seed_reg),
        .x    (x1_reg),
        .y    (y1_reg),
        .side (noise_side)
    );

    itmn_div u_div (
        .clk (clk),
        .en  (en),
        .r0  (r4_reg),
        .m   (m_reg),
        .q   (q)
    );

    itmn_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .v    (q),
        .root (root)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_radius_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.radius <= RADIUS_ONE)
        else $error("radius above one");

    a_sat_is_sea: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.radius == RADIUS_ONE) |-> !result.in_shape)
        else $error("saturated radius marked as land");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result_reg)))
        else $error("held result overwritten");

endmodule

FILE: tb/tb_island_tile_mask_noise_core.sv
// Testbench for the island tile mask and noise core: drives tile requests with bursty
// timing, predicts each result with its own bit-exact island classifier and checks in order.
// Depends on itmn_pkg and island_tile_mask_noise_core.
`timescale 1ns / 1ps

module tb_island_tile_mask_noise_core;
    import itmn_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    tile_valid;
    logic    tile_stall;
    tile_t   tile;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    logic [31:0] cur_seed;
    logic [12:0] cur_width;
    logic [12:0] cur_height;
    result_t     pending_results[$];
    int          mismatch_count;
    int          checked_count;
    int          sent_count;
    bit          hold_off;
    bit          busy_rx;

    island_tile_mask_noise_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tile_valid   (tile_valid),
        .tile_stall   (tile_stall),
        .tile         (tile),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] mix_hash(logic [31:0] x, logic [31:0] y, logic [31:0] s);
        logic [31:0] h;
        h = x * 32'd374761393 + y * 32'd668265263 + s * 32'd2147483647;
        h = (h ^ (h >> 13)) * 32'd1274126177;
        return h ^ (h >> 16);
    endfunction

    function automatic logic [63:0] lattice(logic [31:0] gx, logic [31:0] gy);
        return 64'(mix_hash(gx, gy, cur_seed) & 32'hFFFFF);
    endfunction

    function automatic logic [63:0] lerp(logic [63:0] a, logic [63:0] b, logic [63:0] f);
        return (a * ((64'd1 << 16) - f) + b * f) >> 16;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] fit_size(logic [12:0] v);
        if (v == 0)
            return 1;
        if (v > 4096)
            return 4096;
        return 64'(v);
    endfunction

    function automatic result_t classify_tile(tile_t t);
        result_t     r;
        logic [63:0] step, sx, sy, fx, fy, n, a, b, w, h, d, m, rad, thr;
        logic [31:0] gx, gy;
        logic [31:0] vh;
        longint      dx, dy;
        step = ((64'd15 << 16) + 50) / 100;
        sx = 64'(t.tile_x) * step;
        sy = 64'(t.tile_y) * step;
        gx = 32'(sx >> 16);
        gy = 32'(sy >> 16);
        fx = sx & 64'hFFFF;
        fy = sy & 64'hFFFF;
        a = lerp(lattice(gx, gy), lattice(gx + 1, gy), fx);
        b = lerp(lattice(gx, gy + 1), lattice(gx + 1, gy + 1), fx);
        n = lerp(a, b, fy);
        w = fit_size(cur_width);
        h = fit_size(cur_height);
        dx = 2 * longint'(t.tile_x) - longint'(w);
        dy = 2 * longint'(t.tile_y) - longint'(h);
        d = 64'(dx * dx) + 64'(dy * dy);
        m = w * w + h * h;
        if (d >= m)
            rad = 32768;
        else
            rad = root64((d << 30) / m);
        thr = 64'd620 * 64'hFFFFF + 64'd350 * n - 64'd175 * 64'hFFFFF;
        r.in_shape = (rad * (64'd1000 * 64'hFFFFF) <= thr * 64'd32768);
        vh = mix_hash(32'(t.tile_x), 32'(t.tile_y), cur_seed + 32'd9973);
        r.variant = vh[1:0];
        r.radius = rad[15:0];
        return r;
    endfunction

    task automatic send_tile(input tile_t t);
        tile_valid <= 1'b1;
        tile <= t;
        @(posedge clk);
        while (tile_stall)
            @(posedge clk);
        pending_results.push_back(classify_tile(t));
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_burst_tile(input tile_t t);
        int gap;
        send_tile(t);
        if ($urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 6);
            tile_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        tile_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_SEED:   cur_seed = data;
            CFG_WIDTH:  cur_width = data[12:0];
            CFG_HEIGHT: cur_height = data[12:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_corners_at_reset();
        send_tile('{tile_x: 12'd0, tile_y: 12'd0});
        send_tile('{tile_x: 12'd4095, tile_y: 12'd4095});
        send_tile('{tile_x: 12'd32, tile_y: 12'd32});
        send_tile('{tile_x: 12'd0, tile_y: 12'd4095});
        send_tile('{tile_x: 12'd4095, tile_y: 12'd0});
        send_tile('{tile_x: 12'd31, tile_y: 12'd33});
        send_tile('{tile_x: 12'hAAA, tile_y: 12'h555});
        send_tile('{tile_x: 12'h555, tile_y: 12'hAAA});
        drain_results();
    endtask

    task automatic test_size_extremes();
        write_register(CFG_SEED, 32'hFFFF_FFFF);
        write_register(CFG_WIDTH, 32'd0);
        write_register(CFG_HEIGHT, 32'd0);
        send_tile('{tile_x: 12'd0, tile_y: 12'd0});
        send_tile('{tile_x: 12'd1, tile_y: 12'd0});
        send_tile('{tile_x: 12'd4095, tile_y: 12'd4095});
        drain_results();
        write_register(CFG_WIDTH, 32'h1FFF);
        write_register(CFG_HEIGHT, 32'd4097);
        write_register(2'd3, 32'd17);
        send_tile('{tile_x: 12'd2048, tile_y: 12'd2048});
        send_tile('{tile_x: 12'd0, tile_y: 12'd0});
        send_tile('{tile_x: 12'd4095, tile_y: 12'd0});
        send_tile('{tile_x: 12'd2047, tile_y: 12'd2049});
        drain_results();
        write_register(CFG_WIDTH, 32'd4096);
        write_register(CFG_HEIGHT, 32'd1);
        send_tile('{tile_x: 12'd2048, tile_y: 12'd0});
        send_tile('{tile_x: 12'd2048, tile_y: 12'd1});
        send_tile('{tile_x: 12'd100, tile_y: 12'd4095});
        drain_results();
    endtask

    task automatic test_random_worlds();
        int phase;
        int k;
        int span_x;
        int span_y;
        for (phase = 0; phase < 7; phase++)
        begin
            write_register(CFG_SEED, $urandom());
            write_register(CFG_WIDTH, (phase % 3 == 0) ? $urandom() : $urandom_range(1, 300));
            write_register(CFG_HEIGHT, (phase % 3 == 0) ? $urandom() : $urandom_range(1, 300));
            span_x = (cur_width == 0) ? 1 : cur_width;
            span_y = (cur_height == 0) ? 1 : cur_height;
            span_x = (span_x > 4095) ? 4095 : span_x;
            span_y = (span_y > 4095) ? 4095 : span_y;
            for (k = 0; k < 100; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_burst_tile('{tile_x: 12'($urandom()), tile_y: 12'($urandom())});
                else
                    send_burst_tile('{tile_x: 12'($urandom_range(0, span_x)),
                                      tile_y: 12'($urandom_range(0, span_y))});
            end
            drain_results();
        end
    endtask

    task automatic test_output_backpressure();
        int k;
        write_register(CFG_WIDTH, 32'd64);
        write_register(CFG_HEIGHT, 32'd64);
        hold_off = 1'b1;
        for (k = 0; k < 80; k++)
            send_tile('{tile_x: 12'($urandom_range(0, 64)), tile_y: 12'($urandom_range(0, 64))});
        drain_results();
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (busy_rx)
            result_stall <= 1'b1;
        else if ($urandom_range(0, 63) < 40)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 2) == 0);
    end

    initial
    begin
        busy_rx = 1'b0;
        wait (hold_off);
        busy_rx = 1'b1;
        repeat (300) @(posedge clk);
        busy_rx = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result %p", result);
            end
            else
            begin
                result_t want;
                want = pending_results.pop_front();
                checked_count++;
                if (want.in_shape !== result.in_shape || want.variant !== result.variant
                    || want.radius !== result.radius)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %p, got %p", want, result);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        tile_valid = 1'b0;
        tile = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SEED;
        cfg_data = '0;
        hold_off = 1'b0;
        mismatch_count = 0;
        checked_count = 0;
        sent_count = 0;
        cur_seed = 32'd0;
        cur_width = 13'd64;
        cur_height = 13'd64;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_corners_at_reset();
        test_size_extremes();
        test_random_worlds();
        test_output_backpressure();
        $display("Ran %0d tile requests over reset, degenerate, oversized and random worlds,",
                 sent_count);
        $display("with a long output hold-off; %0d results checked.", checked_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
